FILE: src/bpq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpq_pkg
// shared types and constants for the palette blend and quantize unit
// ----------------------------------------------------------------------------
package bpq_pkg;

    typedef enum logic [2:0] {
        STYLE_TRANSLUCENT = 3'd0,
        STYLE_ADD         = 3'd1,
        STYLE_SUBTRACT    = 3'd2,
        STYLE_REV_SUB     = 3'd3,
        STYLE_MODULATE    = 3'd4
    } style_t;

    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_QUERY = 1'b1
    } cmd_t;

    localparam logic CFG_STYLE  = 1'b0;
    localparam logic CFG_AMOUNT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ_BG,
        ST_READ_FG,
        ST_BLEND,
        ST_DIV,
        ST_SEARCH,
        ST_DRAIN,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } rgb_t;

    // 255 divisor: x/255 for x < 65535 equals (x + 1 + (x >> 8)) >> 8
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] s;
        s = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
        return s[15:8];
    endfunction

    function automatic logic [7:0] blend_chan(input logic [7:0] bg, input logic [7:0] fg,
                                              input logic [2:0] style, input logic [7:0] a,
                                              input logic [15:0] tr_sum);
        logic [16:0] pos;
        logic [16:0] neg;
        logic [16:0] dif;
        logic [15:0] prod;
        pos  = 17'd0;
        neg  = 17'd0;
        dif  = 17'd0;
        prod = 16'd0;
        case (style)
            STYLE_TRANSLUCENT: return (a == 8'd0) ? bg : div255(tr_sum);
            STYLE_ADD:
            begin
                pos = {1'b0, bg, 8'd0} + {1'b0, 16'(fg) * 16'(a)};
                return (pos[16] == 1'b1) ? 8'hFF : pos[15:8];
            end
            STYLE_SUBTRACT:
            begin
                pos = {1'b0, bg, 8'd0};
                neg = {1'b0, 16'(fg) * 16'(a)};
                dif = pos - neg;
                return (pos > neg) ? dif[15:8] : 8'd0;
            end
            STYLE_REV_SUB:
            begin
                pos = {1'b0, 16'(fg) * 16'(a)};
                neg = {1'b0, bg, 8'd0};
                dif = pos - neg;
                return (pos > neg) ? dif[15:8] : 8'd0;
            end
            STYLE_MODULATE:
            begin
                prod = bg * fg;
                return prod[15:8];
            end
            default: return bg;
        endcase
    endfunction

endpackage

FILE: src/blend_and_palette_quantize_unit.sv
`timescale 1ns / 1ps
// a query streams one palette read per entry into a row of three distance cells
// a load registers the entry before writing it; one word is worked on at a time
// results wait in an output register while the next word may be offered
// reset clears control state and the config registers (style 0, amount 128); palette
// contents are undefined until loaded
// ----------------------------------------------------------------------------
// blend_and_palette_quantize_unit
// blends two palette colours and searches the palette for the nearest entry
// ----------------------------------------------------------------------------
module blend_and_palette_quantize_unit #(
    parameter int PALETTE_ENTRIES = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       cmd,
    input  logic [7:0] entry_index,
    input  logic [7:0] back_index,
    input  logic [7:0] front_index,
    input  logic [7:0] load_red,
    input  logic [7:0] load_green,
    input  logic [7:0] load_blue,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] nearest_index,
    output logic [7:0] blend_red,
    output logic [7:0] blend_green,
    output logic [7:0] blend_blue,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data
);
    localparam logic [8:0] LAST = 9'(PALETTE_ENTRIES - 1);

    logic [23:0] mem [0:255];
    logic [23:0] rd_reg;
    logic [7:0]  rd_addr;
    logic        wr_en;
    logic [2:0]  style_reg;
    logic [7:0]  amount_reg;

    bpq_pkg::state_t state_reg, state_next;
    logic [7:0]  fg_idx_reg;
    bpq_pkg::rgb_t bg_reg, fg_reg, col_reg;
    logic [15:0] tr_r_reg, tr_g_reg, tr_b_reg;
    logic [8:0]  cnt_reg, cnt_next;
    logic        issue, issued_reg;
    logic [7:0]  issued_idx_reg;
    logic [17:0] best_reg;
    logic [7:0]  best_idx_reg;
    logic        obuf_full_reg;
    logic        accept;

    logic        c0v, c1v, c2v;
    logic [7:0]  c0i, c1i, c2i;
    logic [17:0] c0s, c1s, c2s;
    logic [23:0] c0r, c1r, c2r;

    assign in_ready = (state_reg == bpq_pkg::ST_IDLE) && !wr_en;
    assign accept   = in_valid && in_ready;
    assign issue    = (state_reg == bpq_pkg::ST_SEARCH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            style_reg  <= 3'd0;
            amount_reg <= 8'd128;
        end
        else if (cfg_we)
        begin
            if (cfg_index == bpq_pkg::CFG_STYLE)
                style_reg <= cfg_data[2:0];
            else
                amount_reg <= cfg_data;
        end
    end

    logic       wr_en_reg;
    logic [7:0] wr_addr_reg;
    logic [23:0] wr_data_reg;
    assign wr_en = wr_en_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            wr_en_reg <= 1'b0;
        else
            wr_en_reg <= accept && (cmd == bpq_pkg::CMD_LOAD);
    end

    always_ff @(posedge clk)
    begin
        wr_addr_reg <= entry_index;
        wr_data_reg <= {load_red, load_green, load_blue};
        if (wr_en_reg)
            mem[wr_addr_reg] <= wr_data_reg;
        rd_reg <= mem[rd_addr];
    end

    always_comb
    begin
        case (state_reg)
            bpq_pkg::ST_IDLE:   rd_addr = back_index;
            bpq_pkg::ST_SEARCH: rd_addr = cnt_reg[7:0];
            default:            rd_addr = fg_idx_reg;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            bpq_pkg::ST_IDLE:
                if (accept && cmd == bpq_pkg::CMD_QUERY)
                    state_next = bpq_pkg::ST_READ_BG;
            bpq_pkg::ST_READ_BG: state_next = bpq_pkg::ST_READ_FG;
            bpq_pkg::ST_READ_FG: state_next = bpq_pkg::ST_BLEND;
            bpq_pkg::ST_BLEND:   state_next = bpq_pkg::ST_DIV;
            bpq_pkg::ST_DIV:
            begin
                state_next = bpq_pkg::ST_SEARCH;
                cnt_next   = 9'd0;
            end
            bpq_pkg::ST_SEARCH:
            begin
                cnt_next = cnt_reg + 9'd1;
                if (cnt_reg == LAST)
                begin
                    state_next = bpq_pkg::ST_DRAIN;
                    cnt_next   = 9'd0;
                end
            end
            bpq_pkg::ST_DRAIN:
            begin
                cnt_next = cnt_reg + 9'd1;
                if (cnt_reg == 9'd4)
                    state_next = bpq_pkg::ST_OUT;
            end
            bpq_pkg::ST_OUT:
                if (!obuf_full_reg || out_ready)
                    state_next = bpq_pkg::ST_IDLE;
            default: state_next = bpq_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= bpq_pkg::ST_IDLE;
            cnt_reg    <= 9'd0;
            issued_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            issued_reg <= issue;
        end
    end

    always_ff @(posedge clk)
    begin
        issued_idx_reg <= cnt_reg[7:0];
        if (accept)
            fg_idx_reg <= front_index;
        if (state_reg == bpq_pkg::ST_READ_BG)
            bg_reg <= rd_reg;
        if (state_reg == bpq_pkg::ST_BLEND)
        begin
            fg_reg   <= rd_reg;
            tr_r_reg <= bg_reg.r * (8'd255 - amount_reg) + rd_reg[23:16] * amount_reg;
            tr_g_reg <= bg_reg.g * (8'd255 - amount_reg) + rd_reg[15:8] * amount_reg;
            tr_b_reg <= bg_reg.b * (8'd255 - amount_reg) + rd_reg[7:0] * amount_reg;
        end
        if (state_reg == bpq_pkg::ST_DIV)
        begin
            col_reg.r <= bpq_pkg::blend_chan(bg_reg.r, fg_reg.r, style_reg, amount_reg, tr_r_reg);
            col_reg.g <= bpq_pkg::blend_chan(bg_reg.g, fg_reg.g, style_reg, amount_reg, tr_g_reg);
            col_reg.b <= bpq_pkg::blend_chan(bg_reg.b, fg_reg.b, style_reg, amount_reg, tr_b_reg);
            best_reg  <= 18'h3FFFF;
        end
        else if (c2v && (c2s < best_reg))
        begin
            best_reg     <= c2s;
            best_idx_reg <= c2i;
        end
    end

    bpq_cell u_cell_r (
        .clk(clk), .rst_n(rst_n), .in_valid(issued_reg), .in_index(issued_idx_reg),
        .target(col_reg.r), .comp(rd_reg[23:16]), .in_sum(17'd0), .in_rest(rd_reg),
        .out_valid(c0v), .out_index(c0i), .out_sum(c0s), .out_rest(c0r)
    );
    bpq_cell u_cell_g (
        .clk(clk), .rst_n(rst_n), .in_valid(c0v), .in_index(c0i),
        .target(col_reg.g), .comp(c0r[15:8]), .in_sum(c0s[16:0]), .in_rest(c0r),
        .out_valid(c1v), .out_index(c1i), .out_sum(c1s), .out_rest(c1r)
    );
    bpq_cell u_cell_b (
        .clk(clk), .rst_n(rst_n), .in_valid(c1v), .in_index(c1i),
        .target(col_reg.b), .comp(c1r[7:0]), .in_sum(c1s[16:0]), .in_rest(c1r),
        .out_valid(c2v), .out_index(c2i), .out_sum(c2s), .out_rest(c2r)
    );

    logic unused_rest;
    assign unused_rest = ^c2r;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            obuf_full_reg <= 1'b0;
        else if (state_reg == bpq_pkg::ST_OUT && (!obuf_full_reg || out_ready))
            obuf_full_reg <= 1'b1;
        else if (out_ready)
            obuf_full_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == bpq_pkg::ST_OUT && (!obuf_full_reg || out_ready))
        begin
            nearest_index <= best_idx_reg;
            blend_red     <= col_reg.r;
            blend_green   <= col_reg.g;
            blend_blue    <= col_reg.b;
        end
    end

    assign out_valid = obuf_full_reg;
endmodule

FILE: src/bpq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpq_cell
// one distance cell: squares one channel difference and passes sums on
// ----------------------------------------------------------------------------
module bpq_cell (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [7:0]  in_index,
    input  logic [7:0]  target,
    input  logic [7:0]  comp,
    input  logic [16:0] in_sum,
    input  logic [23:0] in_rest,
    output logic        out_valid,
    output logic [7:0]  out_index,
    output logic [17:0] out_sum,
    output logic [23:0] out_rest
);
    logic [8:0]  diff;
    logic [15:0] sq;

    always_comb
    begin
        diff = (target >= comp) ? {1'b0, target - comp} : {1'b0, comp - target};
        sq   = diff[7:0] * diff[7:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else
            out_valid <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        out_index <= in_index;
        out_sum   <= {1'b0, in_sum} + {2'd0, sq};
        out_rest  <= in_rest;
    end
endmodule
